>>> hdl/nfsp_pkg.sv
package nfsp_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = 9;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  localparam logic [1:0] KIND_ABSENT = 2'd0;
  localparam logic [1:0] KIND_SHORT  = 2'd1;
  localparam logic [1:0] KIND_LONG   = 2'd2;

  localparam logic [3:0] ESC_NIBBLE = 4'hF;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       miss;
  } res_t;

endpackage

>>> hdl/nfsp_ram.sv
module nfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/nibble_frequency_string_packer.sv
// Packs 7-bit characters into a byte stream of 4-bit codes through a loaded
// code table. Table writes, characters and end-of-string marks enter on the
// in_ channel; one packed byte leaves per out_ word. The block takes one input
// word per cycle unless stalled: the table lookup is one read of a synchronous
// RAM, and the registered read data feeds the packing step, which updates the
// packing state and writes the output queue. An input word yields zero, one
// or two result words, and results drain at one word per cycle while out_ready
// is high, through a four-entry output queue; input stalls only when that
// queue has fewer than two free entries. Table entries read as absent after
// reset through per-entry valid flops, so no clearing pass is needed.
module nibble_frequency_string_packer
  import nfsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [6:0] in_char_code,
  input  logic [1:0] in_entry_kind,
  input  logic [6:0] in_entry_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_string,
  output logic       out_char_missing
);

  logic                   in_acc;
  logic                   in_range;
  logic [TBL_AW-1:0]      tbl_addr;
  logic                   tbl_we;
  logic [1:0]             wr_kind;
  logic [ENTRY_W-1:0]     tbl_rdata;
  logic [TABLE_DEPTH-1:0] tbl_vld_r;

  logic       s1_valid_r;
  logic [1:0] s1_mode_r;
  logic       s1_hit_r;
  logic       s1_go;
  logic [1:0] ent_kind;
  logic [6:0] ent_idx;

  logic       full_r, full_nxt;
  logic [7:0] open_r, open_nxt;
  logic       ov_r, ov_nxt;
  res_t       r0, r1;
  logic [1:0] n_res;

  res_t             oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_AW:0]   oq_cnt_r;
  logic             oq_pop;

  assign in_range = 32'(in_char_code) < 32'(TABLE_DEPTH);
  assign tbl_addr = TBL_AW'(in_char_code);
  assign in_acc   = in_valid && in_ready;
  assign tbl_we   = in_acc && (in_mode == MODE_WRITE) && in_range;
  assign wr_kind  = (in_entry_kind == KIND_SHORT || in_entry_kind == KIND_LONG) ?
                    in_entry_kind : KIND_ABSENT;

  nfsp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_addr),
    .wdata({wr_kind, in_entry_index}),
    .re   (in_acc),
    .raddr(tbl_addr),
    .rdata(tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (tbl_we) begin
      tbl_vld_r[tbl_addr] <= 1'b1;
    end
  end

  assign s1_go    = s1_valid_r && (oq_cnt_r <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_mode;
      s1_hit_r  <= in_range && tbl_vld_r[tbl_addr];
    end
  end

  assign ent_kind = s1_hit_r ? tbl_rdata[8:7] : KIND_ABSENT;
  assign ent_idx  = tbl_rdata[6:0];

  always_comb begin
    full_nxt = full_r;
    open_nxt = open_r;
    ov_nxt   = ov_r;
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    if (s1_go) begin
      case (s1_mode_r)
        MODE_ENCODE: begin
          if (ent_kind == KIND_SHORT) begin
            if (full_r) begin
              if (ov_r) begin
                r0.byte_val = open_r;
                n_res       = 2'd1;
              end
              open_nxt = {4'b0, ent_idx[3:0]};
              ov_nxt   = 1'b1;
              full_nxt = 1'b0;
            end else begin
              open_nxt = open_r + {ent_idx[3:0], 4'b0};
              full_nxt = 1'b1;
            end
          end else if (ent_kind == KIND_LONG) begin
            if (full_r) begin
              if (ov_r) begin
                r0.byte_val = open_r;
                r1.byte_val = {1'b0, ent_idx[6:4], ESC_NIBBLE};
                n_res       = 2'd2;
              end else begin
                r0.byte_val = {1'b0, ent_idx[6:4], ESC_NIBBLE};
                n_res       = 2'd1;
              end
              open_nxt = {4'b0, ent_idx[3:0]};
              ov_nxt   = 1'b1;
              full_nxt = 1'b0;
            end else begin
              r0.byte_val = open_r + {ESC_NIBBLE, 4'b0};
              n_res       = 2'd1;
              open_nxt    = {1'b0, ent_idx};
              ov_nxt      = 1'b1;
              full_nxt    = 1'b1;
            end
          end else begin
            r0.miss = 1'b1;
            n_res   = 2'd1;
          end
        end
        MODE_END: begin
          if (ov_r && open_r != 8'd0) begin
            r0.byte_val = open_r;
            r1.last     = 1'b1;
            n_res       = 2'd2;
          end else begin
            r0.last = 1'b1;
            n_res   = 2'd1;
          end
          full_nxt = 1'b1;
          open_nxt = 8'd0;
          ov_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b1;
      open_r <= 8'd0;
      ov_r   <= 1'b0;
    end else begin
      full_r <= full_nxt;
      open_r <= open_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign oq_pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wp_r  <= oq_wp_r + OQ_AW'(n_res);
      oq_rp_r  <= oq_rp_r + OQ_AW'(oq_pop);
      oq_cnt_r <= oq_cnt_r + (OQ_AW+1)'(n_res) - (OQ_AW+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      oq_r[oq_wp_r] <= r0;
    end
    if (n_res == 2'd2) begin
      oq_r[oq_wp_r + OQ_AW'(1)] <= r1;
    end
  end

  assign out_valid          = oq_cnt_r != '0;
  assign out_byte           = oq_r[oq_rp_r].byte_val;
  assign out_last_of_string = oq_r[oq_rp_r].last;
  assign out_char_missing   = oq_r[oq_rp_r].miss;

endmodule

>>> hdl/nfsp_checker.sv
module nfsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_of_string,
  input logic       out_char_missing
);

  // A stalled result word keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_last_of_string) && $stable(out_char_missing))
    else $error("result word changed while stalled");

  // An error word carries a zero byte and never closes a string.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_missing |-> out_byte == 8'd0 && !out_last_of_string)
    else $error("malformed missing-character word");

  // Reset leaves no result word pending.
  assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> !out_valid)
    else $error("result word pending after reset");

endmodule

bind nibble_frequency_string_packer nfsp_checker u_nfsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte          (out_byte),
  .out_last_of_string(out_last_of_string),
  .out_char_missing  (out_char_missing)
);
